// ----- src/pulse_width_sensor_frame_decoder_top_defines.svh -----
// Assertion macros shared by the decoder modules.
// Each module that asserts has signals named clk and rst_n in scope.
`ifndef PULSE_WIDTH_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH
`define PULSE_WIDTH_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PWSFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PWSFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PWSFD_ASSERT(label, prop, msg)
`define PWSFD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- src/pwsfd_pkg.sv -----
`timescale 1ns / 1ps
package pwsfd_pkg;

    localparam int unsigned BIT_COUNT       = 28;
    localparam int unsigned INDEX_WIDTH     = 7;
    localparam int unsigned CFG_DATA_WIDTH  = 16;

    localparam logic [6:0]  FRAME_PULSES    = 7'd58;
    localparam logic [6:0]  LAST_BIT_PULSE  = 7'd56;
    localparam logic [6:0]  INDEX_MAX       = 7'd127;
    localparam logic [11:0] NEG_LIMIT       = 12'd3000;
    localparam logic [15:0] NEG_FLAG        = 16'h8000;

    localparam logic [7:0]  SCALE_RESET     = 8'd30;
    localparam logic [15:0] THRESHOLD_RESET = 16'd2975;

    localparam logic CFG_PULSE_SCALE    = 1'b0;
    localparam logic CFG_LONG_THRESHOLD = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_LENGTH   = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // One closed frame as handed from the front end to the decoder.
    typedef struct packed {
        logic                 length_ok;
        logic [BIT_COUNT-1:0] bits;
    } frame_t;

    typedef struct packed {
        logic   push;
        frame_t frame;
    } queue_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- src/pwsfd_front.sv -----
`timescale 1ns / 1ps
module pwsfd_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic                             cfg_index,
    input  logic [pwsfd_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       pulse_width,
    input  logic                             frame_end,
    input  pwsfd_pkg::queue_status_t         queue_status,
    output pwsfd_pkg::queue_push_t           queue_push
);
    import pwsfd_pkg::*;

    logic [7:0]             scale_reg;
    logic [15:0]            threshold_reg;
    logic [INDEX_WIDTH-1:0] index_reg;
    logic [INDEX_WIDTH-1:0] index_next;
    logic [BIT_COUNT-1:0]   bits_reg;
    logic [BIT_COUNT-1:0]   bits_next;
    logic [INDEX_WIDTH-1:0] index_inc;
    logic [BIT_COUNT-1:0]   bits_shift;
    logic [15:0]            product;
    logic                   bit_slot;
    logic                   bit_value;
    logic                   accept;

    // The front end only holds back when the queue has no room.
    assign in_stall = queue_status.full;
    assign accept   = in_valid && !in_stall;

    assign index_inc = (index_reg < INDEX_MAX) ? index_reg + 1'b1 : index_reg;
    assign bit_slot  = !index_inc[0] && (index_inc >= 7'd2) && (index_inc <= LAST_BIT_PULSE);
    assign product   = {8'd0, pulse_width} * {8'd0, scale_reg};
    assign bit_value = product > threshold_reg;
    assign bits_shift = bit_slot ? {bits_reg[BIT_COUNT-2:0], bit_value} : bits_reg;

    always_comb
    begin
        index_next = index_reg;
        bits_next  = bits_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                index_next = '0;
                bits_next  = '0;
            end
            else
            begin
                index_next = index_inc;
                bits_next  = bits_shift;
            end
        end
    end

    assign queue_push.push            = accept && frame_end;
    assign queue_push.frame.length_ok = index_inc == FRAME_PULSES;
    assign queue_push.frame.bits      = bits_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_RESET;
            threshold_reg <= THRESHOLD_RESET;
            index_reg     <= '0;
            bits_reg      <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_PULSE_SCALE)
            begin
                scale_reg <= cfg_data[7:0];
            end
            if (cfg_write && cfg_index == CFG_LONG_THRESHOLD)
            begin
                threshold_reg <= cfg_data[15:0];
            end
            index_reg <= index_next;
            bits_reg  <= bits_next;
        end
    end

endmodule

// ----- src/pwsfd_queue.sv -----
`timescale 1ns / 1ps
`include "pulse_width_sensor_frame_decoder_top_defines.svh"
module pwsfd_queue
#(
    parameter int unsigned DEPTH = pwsfd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pwsfd_pkg::queue_push_t   queue_push,
    input  logic                     pop,
    output pwsfd_pkg::queue_status_t queue_status,
    output pwsfd_pkg::frame_t        head
);
    import pwsfd_pkg::*;

    localparam int unsigned PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned COUNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0]   LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

    frame_t                 entry_reg [DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [PTR_WIDTH-1:0]   wr_ptr_next;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [PTR_WIDTH-1:0]   rd_ptr_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign queue_status.full  = count_reg == FULL_COUNT;
    assign queue_status.empty = count_reg == '0;
    assign head               = entry_reg[rd_ptr_reg];

    assign do_push = queue_push.push && !queue_status.full;
    assign do_pop  = pop && !queue_status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= queue_push.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PWSFD_ASSERT(a_count_in_range, count_reg <= FULL_COUNT, "queue count beyond depth")
    `PWSFD_ASSERT(a_no_push_when_full, queue_status.full |-> !queue_push.push,
                  "frame pushed into a full queue")
    `PWSFD_ASSERT(a_pointers_track_count,
                  (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1,
                  "queue count did not follow a push")

endmodule

// ----- src/pwsfd_back.sv -----
`timescale 1ns / 1ps
`include "pulse_width_sensor_frame_decoder_top_defines.svh"
module pwsfd_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pwsfd_pkg::queue_status_t queue_status,
    input  pwsfd_pkg::frame_t        head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [7:0]               sequence_res,
    output logic [7:0]               device_id,
    output logic [1:0]               channel,
    output logic [15:0]              temperature
);
    import pwsfd_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  counter_reg;
    logic [7:0]  counter_next;
    logic [1:0]  status_reg;
    logic [7:0]  sequence_reg;
    logic [7:0]  device_reg;
    logic [1:0]  channel_reg;
    logic [15:0] temperature_reg;
    logic [1:0]  status_next;
    logic [7:0]  device_next;
    logic [1:0]  channel_next;
    logic [15:0] temperature_next;
    logic [3:0]  nib [7];
    logic [6:0]  nibble_sum;
    logic [3:0]  check_value;
    logic [11:0] raw_temp;
    logic        load;

    // Nibble 0 is the first one received and sits at the top of the word.
    always_comb
    begin
        for (int k = 0; k < 7; k++)
        begin
            nib[k] = head.bits[BIT_COUNT-1-4*k -: 4];
        end
    end

    assign nibble_sum  = 7'(nib[1]) + 7'(nib[2]) + 7'(nib[3])
                       + 7'(nib[4]) + 7'(nib[5]) + 7'(nib[6]);
    assign check_value = nibble_sum[3:0] - 4'd1;
    assign raw_temp    = {nib[3], nib[4], nib[5]};

    always_comb
    begin
        status_next      = STATUS_OK;
        device_next      = '0;
        channel_next     = '0;
        temperature_next = '0;
        if (!head.length_ok)
        begin
            status_next = STATUS_LENGTH;
        end
        else if (check_value != nib[0])
        begin
            status_next = STATUS_CHECKSUM;
        end
        else
        begin
            device_next  = {nib[1], nib[2]};
            channel_next = nib[6][3:2];
            // Negative readings are stored as an offset below 4096.
            if (raw_temp > NEG_LIMIT)
            begin
                temperature_next = NEG_FLAG | {4'd0, 12'd0 - raw_temp};
            end
            else
            begin
                temperature_next = {4'd0, raw_temp};
            end
        end
    end

    assign load = !queue_status.empty && (!out_valid_reg || !out_stall);
    assign pop  = load;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        counter_next   = counter_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (status_next == STATUS_OK)
            begin
                counter_next = counter_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg      <= status_next;
            sequence_reg    <= counter_reg;
            device_reg      <= device_next;
            channel_reg     <= channel_next;
            temperature_reg <= temperature_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            counter_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            counter_reg   <= counter_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign sequence_res = sequence_reg;
    assign device_id    = device_reg;
    assign channel      = channel_reg;
    assign temperature  = temperature_reg;

    `PWSFD_ASSERT(a_counter_on_good,
                  (load && status_next == STATUS_OK) |=> counter_reg == $past(counter_reg) + 8'd1,
                  "sequence number did not advance after a good packet")
    `PWSFD_ASSERT(a_counter_hold_on_error,
                  (load && status_next != STATUS_OK) |=> $stable(counter_reg),
                  "sequence number moved on an error result")
    `PWSFD_ASSERT(a_error_fields_zero,
                  (out_valid_reg && status_reg != STATUS_OK) |-> (device_reg == '0
                  && channel_reg == '0 && temperature_reg == '0),
                  "error result carries decoded fields")

endmodule

// ----- src/pulse_width_sensor_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// Pulse-width sensor frame decoder.
// Input channel: one beat per received pulse (pulse_width, frame_end) on
// in_valid/in_stall. Each even pulse from 2 to 56 contributes one data bit,
// which is 1 when pulse_width times pulse_scale exceeds long_threshold.
// The beat carrying frame_end closes the frame and yields exactly one result
// beat on out_valid/out_stall: status, sequence_res, device_id, channel and
// temperature. Other beats produce no result.
// Throughput: one pulse per cycle while in_stall is low, set by the single 8x8
// multiply and compare in the front end. A closing beat is written into the
// frame queue when it is accepted and then loaded into the output register,
// which raises out_valid; older frames or an output stall can hold it back.
// The front end and the result stage are parted by a frame queue of
// QUEUE_DEPTH entries, so pulses keep flowing while a result waits. in_stall
// rises only when the queue is full, that is when the receiver has stalled
// long enough for QUEUE_DEPTH closed frames plus the one in the output
// register to pile up.
// Configuration: cfg_write with cfg_index 0 loads pulse_scale from
// cfg_data[7:0], index 1 loads long_threshold from cfg_data[15:0]; write only
// while the block is idle.
// Reset sets pulse_scale to 30, long_threshold to 2975, clears the pulse
// count, the collected bits, the sequence number and the queue.
module pulse_width_sensor_frame_decoder_top
#(
    parameter int unsigned QUEUE_DEPTH = pwsfd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [pwsfd_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           pulse_width,
    input  logic                                 frame_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [7:0]                           sequence_res,
    output logic [7:0]                           device_id,
    output logic [1:0]                           channel,
    output logic [15:0]                          temperature
);
    import pwsfd_pkg::*;

    queue_push_t   queue_push;
    queue_status_t queue_status;
    frame_t        head;
    logic          pop;

    // Front end: counts pulses, samples bits and closes frames.
    pwsfd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pulse_width  (pulse_width),
        .frame_end    (frame_end),
        .queue_status (queue_status),
        .queue_push   (queue_push)
    );

    // Closed frames wait here until the result stage can take them.
    pwsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_push   (queue_push),
        .pop          (pop),
        .queue_status (queue_status),
        .head         (head)
    );

    // Result stage: checks length and checksum, extracts the fields and
    // keeps the packet sequence number.
    pwsfd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .sequence_res (sequence_res),
        .device_id    (device_id),
        .channel      (channel),
        .temperature  (temperature)
    );

endmodule

// ----- bench/tb_pulse_width_sensor_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the pulse-width sensor frame decoder. A scoreboard
// object mirrors the decoder: it counts pulses, collects the data bits and
// keeps the sequence number. It queues one expected result for every closing
// beat. The output side compares each result beat with the oldest entry.
module tb_pulse_width_sensor_frame_decoder_top;
    import pwsfd_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int unsigned IDLE_LIMIT      = 4000;
    // Margin after the last owed result arrives, before the bench moves on.
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam logic [15:0] NEG_BASE        = 16'd4096;
    localparam int unsigned MIN_PULSES      = 1300;
    localparam int unsigned OVERFLOW_PULSES = 130;
    localparam int unsigned FIXED_PHASES    = 6;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  sequence_res;
        logic [7:0]  device_id;
        logic [1:0]  channel;
        logic [15:0] temperature;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  pulse_width = '0;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [7:0]  sequence_res;
    logic [7:0]  device_id;
    logic [1:0]  channel;
    logic [15:0] temperature;

    // When calm is set, neither the sender nor the receiver inserts gaps.
    bit          calm = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned pulses_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned config_writes = 0;
    int unsigned stall_left = 0;
    int unsigned phase;

    // The scoreboard mirrors the decoder state and holds the results that
    // are still owed by the block, oldest first.
    class frame_scoreboard;
        logic [7:0]  scale;
        logic [15:0] threshold;
        logic [6:0]  pulse_count;
        logic [27:0] bits;
        logic [7:0]  seq_num;
        decoded_t    owed_q[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned good_frames;
        int unsigned length_errors;
        int unsigned checksum_errors;
        int unsigned negative_temps;

        function new();
            scale           = SCALE_RESET;
            threshold       = THRESHOLD_RESET;
            pulse_count     = '0;
            bits            = '0;
            seq_num         = '0;
            errors          = 0;
            results_seen    = 0;
            good_frames     = 0;
            length_errors   = 0;
            checksum_errors = 0;
            negative_temps  = 0;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void write_reg(logic idx, logic [15:0] value);
            if (idx == CFG_PULSE_SCALE)
                scale = value[7:0];
            else
                threshold = value;
        endfunction

        function void note_pulse(logic [7:0] width, logic last);
            logic [15:0] scaled;
            logic [3:0]  sum;
            logic [11:0] raw_temp;
            decoded_t    r;
            if (pulse_count < INDEX_MAX)
                pulse_count++;
            if (!pulse_count[0] && pulse_count >= 7'd2 && pulse_count <= LAST_BIT_PULSE)
            begin
                scaled = 16'(width) * 16'(scale);
                bits   = {bits[26:0], scaled > threshold};
            end
            if (!last)
                return;
            r = '0;
            r.sequence_res = seq_num;
            if (pulse_count != FRAME_PULSES)
            begin
                r.status = STATUS_LENGTH;
            end
            else
            begin
                sum = bits[23:20] + bits[19:16] + bits[15:12] + bits[11:8]
                    + bits[7:4] + bits[3:0] - 4'd1;
                if (sum != bits[27:24])
                begin
                    r.status = STATUS_CHECKSUM;
                end
                else
                begin
                    r.status    = STATUS_OK;
                    r.device_id = bits[23:16];
                    r.channel   = bits[3:2];
                    raw_temp    = bits[15:4];
                    if (raw_temp > NEG_LIMIT)
                        r.temperature = NEG_FLAG | (NEG_BASE - 16'(raw_temp));
                    else
                        r.temperature = 16'(raw_temp);
                    seq_num++;
                end
            end
            pulse_count = '0;
            bits        = '0;
            owed_q.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
                         $time, field, results_seen, want, got);
                errors++;
            end
        endfunction

        function void check_result(decoded_t got);
            decoded_t want;
            if (owed_q.size() == 0)
            begin
                $display("%0t: result beat with no frame pending: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            results_seen++;
            compare("status", 16'(want.status), 16'(got.status));
            compare("sequence_res", 16'(want.sequence_res), 16'(got.sequence_res));
            compare("device_id", 16'(want.device_id), 16'(got.device_id));
            compare("channel", 16'(want.channel), 16'(got.channel));
            compare("temperature", want.temperature, got.temperature);
            case (want.status)
                STATUS_OK:       good_frames++;
                STATUS_LENGTH:   length_errors++;
                default:         checksum_errors++;
            endcase
            if (want.status == STATUS_OK && want.temperature[15])
                negative_temps++;
        endfunction
    endclass

    frame_scoreboard sb;

    pulse_width_sensor_frame_decoder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pulse_width  (pulse_width),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .sequence_res (sequence_res),
        .device_id    (device_id),
        .channel      (channel),
        .temperature  (temperature)
    );

    always #5 clk = ~clk;

    // Gap lengths for both sides: mostly none, often short, and now and then a long
    // pause; none at all while calm is set.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Receiver: stall runs of random length, with out_stall dropped between runs.
    // Driven on the falling edge so that the rising edge sees settled values.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Every accepted result beat is checked against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, sequence_res, device_id, channel, temperature});
    end

    // The watchdog ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_pulse_width_sensor_frame_decoder_top: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one pulse beat and holds it until the block takes it. Valid is
    // left high after the beat so that back-to-back beats never lower and
    // raise it within one time step.
    task automatic send_pulse(input logic [7:0] width, input logic last);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pulse_width <= width;
        frame_end   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_pulse(width, last);
        pulses_sent++;
    endtask

    // Stops sending, waits for every owed result and lets the block settle.
    // This is where the sender holds off until the output side has caught up.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle, right after a drain.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, value);
        config_writes++;
    endtask

    // Picks a raw width that decodes as the wanted bit under the current
    // settings. When the settings allow only one outcome, any width will do.
    function automatic logic [7:0] width_for(input logic one);
        int unsigned q;
        q = (sb.scale == 0) ? 65535 : sb.threshold / sb.scale;
        if (q >= 255)
            return 8'($urandom_range(255, 0));
        if (one)
            return 8'($urandom_range(255, q + 1));
        return 8'($urandom_range(q, 0));
    endfunction

    // Seven nibbles, first received on top: checksum, two ID nibbles, three
    // temperature nibbles, and the channel nibble. A nonzero skew breaks the
    // checksum on purpose.
    function automatic logic [27:0] build_payload(input logic [7:0] dev,
                                                  input logic [1:0] chan,
                                                  input logic [11:0] temp,
                                                  input logic [1:0] spare,
                                                  input logic [3:0] skew);
        logic [3:0] last_nibble;
        logic [3:0] check;
        last_nibble = {chan, spare};
        check = dev[7:4] + dev[3:0] + temp[11:8] + temp[7:4] + temp[3:0]
              + last_nibble - 4'd1 + skew;
        return {check, dev, temp, last_nibble};
    endfunction

    // Sends a frame of the given pulse count. Even pulses up to 56 carry the
    // payload bits; odd and trailing pulses get random widths.
    task automatic send_frame(input int unsigned count, input logic [27:0] payload);
        int unsigned pos;
        logic [7:0]  width;
        for (pos = 1; pos <= count; pos++)
        begin
            if (pos % 2 == 0 && pos <= 56)
                width = width_for(payload[28 - pos / 2]);
            else
                width = 8'($urandom_range(255, 0));
            send_pulse(width, pos == count);
        end
        frames_sent++;
    endtask

    // Mostly well-formed frames with random content, so the checksum and the
    // field extraction get exercised; the rest are broken frames and noise.
    task automatic random_frame();
        int unsigned kind;
        int unsigned count;
        logic [11:0] temp;
        kind = $urandom_range(99, 0);
        if ($urandom_range(3, 0) == 0)
            temp = 12'($urandom_range(4095, 2990));
        else
            temp = 12'($urandom_range(4095, 0));
        if (kind < 70)
        begin
            send_frame(58, build_payload(8'($urandom), 2'($urandom), temp,
                                         2'($urandom), 4'd0));
        end
        else if (kind < 80)
        begin
            send_frame(58, build_payload(8'($urandom), 2'($urandom), temp,
                                         2'($urandom), 4'($urandom_range(15, 1))));
        end
        else if (kind < 88)
        begin
            count = $urandom_range(70, 1);
            if (count == 58)
                count = 57;
            send_frame(count, 28'($urandom));
        end
        else if (kind < 91)
        begin
            send_frame($urandom_range(140, 120), 28'($urandom));
        end
        else
        begin
            // Noise: short bursts with the frame end set at random.
            count = $urandom_range(20, 1);
            repeat (count - 1)
                send_pulse(8'($urandom), $urandom_range(3, 0) == 0);
            send_pulse(8'($urandom), 1'b1);
            frames_sent++;
        end
    endtask

    initial
    begin
        logic [7:0]  scale;
        logic [15:0] thr;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset settings: temperature at zero, at
        // the negation limit, just above it and at the top; an all-ones ID
        // and channel; a broken checksum; lengths one short, one long, a
        // single pulse, two pulses, and a count that saturates.
        send_frame(58, build_payload(8'h00, 2'd0, 12'd0, 2'd0, 4'd0));
        send_frame(58, build_payload(8'hff, 2'd3, 12'd3000, 2'd3, 4'd0));
        send_frame(58, build_payload(8'h5a, 2'd1, 12'd3001, 2'd0, 4'd0));
        send_frame(58, build_payload(8'ha5, 2'd2, 12'hfff, 2'd1, 4'd0));
        send_frame(58, build_payload(8'h3c, 2'd0, 12'd1234, 2'd2, 4'd1));
        send_frame(57, build_payload(8'h12, 2'd1, 12'd100, 2'd0, 4'd0));
        send_frame(59, build_payload(8'h12, 2'd1, 12'd100, 2'd0, 4'd0));
        send_frame(1, 28'd0);
        send_frame(2, 28'hfffffff);
        send_frame(OVERFLOW_PULSES, 28'($urandom));
        drain();

        // Random phases. The first few use the extreme settings and then the
        // reset values again; later phases pick settings at random. The
        // upper bits of a scale write are random and must be ignored.
        for (phase = 0; phase < FIXED_PHASES || pulses_sent < MIN_PULSES; phase++)
        begin
            case (phase)
                0:
                begin
                    scale = 8'd1;
                    thr   = 16'd0;
                end
                1:
                begin
                    scale = 8'd255;
                    thr   = 16'd65535;
                end
                2:
                begin
                    scale = 8'd255;
                    thr   = 16'd0;
                end
                3:
                begin
                    scale = 8'd1;
                    thr   = 16'd65535;
                end
                4:
                begin
                    scale = SCALE_RESET;
                    thr   = THRESHOLD_RESET;
                end
                default:
                begin
                    scale = 8'($urandom_range(255, 1));
                    if ($urandom_range(3, 0) == 0)
                        thr = 16'($urandom_range(65535, 0));
                    else
                        thr = 16'(scale * $urandom_range(200, 10)
                                  + $urandom_range(scale - 1, 0));
                end
            endcase
            write_reg(CFG_PULSE_SCALE, {8'($urandom), scale});
            write_reg(CFG_LONG_THRESHOLD, thr);
            calm = ($urandom_range(3, 0) == 0);
            repeat ($urandom_range(3, 2))
                random_frame();
            drain();
        end
        calm = 1'b0;

        $display("Sent %0d pulses in %0d frames over %0d register writes.",
                 pulses_sent, frames_sent, config_writes);
        $display("Checked %0d results: %0d good (%0d below zero), %0d length, %0d checksum.",
                 sb.results_seen, sb.good_frames, sb.negative_temps,
                 sb.length_errors, sb.checksum_errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_pulse_width_sensor_frame_decoder_top: PASS");
        else
            $display("tb_pulse_width_sensor_frame_decoder_top: FAIL");
        $finish;
    end
endmodule

// ----- pulse_width_sensor_frame_decoder_top.f -----
+incdir+src
src/pwsfd_pkg.sv
src/pwsfd_front.sv
src/pwsfd_queue.sv
src/pwsfd_back.sv
src/pulse_width_sensor_frame_decoder_top.sv
bench/tb_pulse_width_sensor_frame_decoder_top.sv
